// File: rtl/ecmp_pkg.sv
// shared constants, types and hash helper functions for the ecmp next-hop selector
// no dependencies; imported by every module of the block

package ecmp_pkg;

    localparam int DEF_MAX_NEXT_HOPS = 64;

    localparam int HASH_W  = 32;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int PROTO_W = 8;

    // accepted protocol numbers
    localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'h06;
    localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'h11;
    localparam logic [PROTO_W-1:0] PROTO_ACK  = 8'hFC;
    localparam logic [PROTO_W-1:0] PROTO_NACK = 8'hFD;

    // murmur3 x86_32 constants
    localparam logic [HASH_W-1:0] MM_C1     = 32'hcc9e2d51;
    localparam logic [HASH_W-1:0] MM_C2     = 32'h1b873593;
    localparam logic [HASH_W-1:0] MM_N      = 32'he6546b64;
    localparam logic [HASH_W-1:0] MM_F1     = 32'h85ebca6b;
    localparam logic [HASH_W-1:0] MM_F2     = 32'hc2b2ae35;
    localparam logic [HASH_W-1:0] KEY_BYTES = 32'd12;

    // decoupling queue and remainder pipeline shape
    localparam int QUEUE_DEPTH        = 4;
    localparam int MOD_BITS_PER_STAGE = 4;
    localparam int MOD_STAGES         = HASH_W / MOD_BITS_PER_STAGE;
    localparam int HASH_STAGES        = 8;

    typedef struct packed {
        logic [HASH_W-1:0] w0;
        logic [HASH_W-1:0] w1;
        logic [HASH_W-1:0] w2;
    } flow_key_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    // width of a hop count that can hold max_hops itself
    function automatic int hop_w(input int max_hops);
        return $clog2(max_hops + 1);
    endfunction

    // width of an index below max_hops, at least one bit
    function automatic int idx_w(input int max_hops);
        return (max_hops > 1) ? $clog2(max_hops) : 1;
    endfunction

    function automatic logic [HASH_W-1:0] rotl15(input logic [HASH_W-1:0] x);
        return {x[16:0], x[31:17]};
    endfunction

    function automatic logic [HASH_W-1:0] rotl13(input logic [HASH_W-1:0] x);
        return {x[18:0], x[31:19]};
    endfunction

    // h ^= k; h = rotl13(h); h = h * 5 + n
    function automatic logic [HASH_W-1:0] mix_h(input logic [HASH_W-1:0] h,
                                                input logic [HASH_W-1:0] k);
        logic [HASH_W-1:0] x;
        x = rotl13(h ^ k);
        return x + {x[HASH_W-3:0], 2'b00} + MM_N;
    endfunction

endpackage

// File: rtl/ecmp_flow_hash_next_hop_select.sv
// top level of the ecmp next-hop selector: seed register, front end, queue, back end
// depends on ecmp_pkg, ecmp_front, ecmp_queue and ecmp_back

// Picks one of hop_count equal-cost next hops per packet header. The flow key is
// {src_addr, dst_addr, dst_port:src_port}, hashed with murmur3 x86_32 from the
// hash_seed register; hop_index is the hash modulo hop_count. flow_hash is always
// given. An unsupported protocol (anything but tcp, udp, ack, nack) or a hop count
// of zero or above MAX_NEXT_HOPS sets select_error and forces hop_index to 0.
// Throughput is one beat per clock, sustained: a header can be accepted every cycle
// while the output is not stalled. On its way from input beat to output beat a header
// passes the front register, loaded on the accepting edge, then one queue write,
// eight hash stages, eight remainder stages of four dividend bits each and one output
// register. A stalled output freezes the back end;
// the front end keeps accepting until its register and the four-entry queue fill.
// hash_seed is written by hash_seed_we/hash_seed_wdata and should only change while
// no beat is in flight.

module ecmp_flow_hash_next_hop_select
    import ecmp_pkg::*;
#(
    parameter int MAX_NEXT_HOPS = DEF_MAX_NEXT_HOPS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // seed register write
    input  logic                              hash_seed_we,
    input  logic [HASH_W-1:0]                 hash_seed_wdata,
    // header channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ADDR_W-1:0]                 src_addr,
    input  logic [ADDR_W-1:0]                 dst_addr,
    input  logic [PROTO_W-1:0]                protocol,
    input  logic [PORT_W-1:0]                 src_port,
    input  logic [PORT_W-1:0]                 dst_port,
    input  logic [hop_w(MAX_NEXT_HOPS)-1:0]   hop_count,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [idx_w(MAX_NEXT_HOPS)-1:0]   hop_index,
    output logic [HASH_W-1:0]                 flow_hash,
    output logic                              select_error
);

    localparam int HOP_W   = hop_w(MAX_NEXT_HOPS);
    localparam int ENTRY_W = $bits(flow_key_t) + 1 + HOP_W;

    logic [HASH_W-1:0]  hash_seed_reg;

    // front end to queue
    queue_status_t      q_status;
    logic               q_push;
    flow_key_t          fr_key;
    logic               fr_err;
    logic [HOP_W-1:0]   fr_hops;

    // queue to back end
    logic               q_pop;
    logic [ENTRY_W-1:0] q_rd_data;
    flow_key_t          bk_key;
    logic               bk_err;
    logic [HOP_W-1:0]   bk_hops;

    // seed register, reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg <= '0;
        end
        else if (hash_seed_we)
        begin
            hash_seed_reg <= hash_seed_wdata;
        end
    end

    ecmp_front #(
        .MAX_NEXT_HOPS (MAX_NEXT_HOPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .src_addr  (src_addr),
        .dst_addr  (dst_addr),
        .protocol  (protocol),
        .src_port  (src_port),
        .dst_port  (dst_port),
        .hop_count (hop_count),
        .q_status  (q_status),
        .q_push    (q_push),
        .key       (fr_key),
        .err       (fr_err),
        .hops      (fr_hops)
    );

    // queue entry: key, error flag, hop count
    ecmp_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data ({fr_key, fr_err, fr_hops}),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    assign {bk_key, bk_err, bk_hops} = q_rd_data;

    ecmp_back #(
        .MAX_NEXT_HOPS (MAX_NEXT_HOPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .hash_seed    (hash_seed_reg),
        .q_status     (q_status),
        .q_key        (bk_key),
        .q_err        (bk_err),
        .q_hops       (bk_hops),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hop_index    (hop_index),
        .flow_hash    (flow_hash),
        .select_error (select_error)
    );

    // an error beat never carries a nonzero index
    a_err_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && select_error |-> hop_index == '0)
        else $error("error beat with nonzero hop_index");

    // the front end only backs up when the queue has no room
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_status.full)
        else $error("input stalled while queue has room");

    // a pop only happens on a queue entry that is there
    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_status.valid)
        else $error("pop from empty queue");

endmodule

// File: rtl/ecmp_front.sv
// front end: takes header beats, checks protocol and hop count, builds the flow key
// depends on ecmp_pkg; feeds ecmp_queue

module ecmp_front
    import ecmp_pkg::*;
#(
    parameter int MAX_NEXT_HOPS = DEF_MAX_NEXT_HOPS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ADDR_W-1:0]                 src_addr,
    input  logic [ADDR_W-1:0]                 dst_addr,
    input  logic [PROTO_W-1:0]                protocol,
    input  logic [PORT_W-1:0]                 src_port,
    input  logic [PORT_W-1:0]                 dst_port,
    input  logic [hop_w(MAX_NEXT_HOPS)-1:0]   hop_count,
    input  queue_status_t                     q_status,
    output logic                              q_push,
    output flow_key_t                         key,
    output logic                              err,
    output logic [hop_w(MAX_NEXT_HOPS)-1:0]   hops
);

    localparam int HOP_W = hop_w(MAX_NEXT_HOPS);

    logic              fr_valid_reg;
    logic              fr_valid_next;
    flow_key_t         key_reg;
    logic              err_reg;
    logic [HOP_W-1:0]  hops_reg;
    logic              accept;
    logic              proto_ok;
    logic              hops_ok;

    always_comb
    begin
        case (protocol) inside
            PROTO_TCP, PROTO_UDP, PROTO_ACK, PROTO_NACK: proto_ok = 1'b1;
            default:                                     proto_ok = 1'b0;
        endcase
    end

    assign hops_ok = (hop_count != '0) && (hop_count <= HOP_W'(MAX_NEXT_HOPS));

    assign in_stall = fr_valid_reg && q_status.full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = fr_valid_reg && !q_status.full;

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (accept)
        begin
            fr_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg.w0 <= src_addr;
            key_reg.w1 <= dst_addr;
            key_reg.w2 <= {dst_port, src_port};
            err_reg    <= !(proto_ok && hops_ok);
            hops_reg   <= hop_count;
        end
    end

    assign key  = key_reg;
    assign err  = err_reg;
    assign hops = hops_reg;

endmodule

// File: rtl/ecmp_queue.sv
// short flop-based fifo between the front end and the hash pipeline
// depends on ecmp_pkg for the status struct

module ecmp_queue
    import ecmp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output queue_status_t    status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/ecmp_back.sv
// back end: pipelined murmur3 hash of the flow key, pipelined remainder, output register
// depends on ecmp_pkg; pulls entries from ecmp_queue

module ecmp_back
    import ecmp_pkg::*;
#(
    parameter int MAX_NEXT_HOPS = DEF_MAX_NEXT_HOPS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [HASH_W-1:0]                 hash_seed,
    input  queue_status_t                     q_status,
    input  flow_key_t                         q_key,
    input  logic                              q_err,
    input  logic [hop_w(MAX_NEXT_HOPS)-1:0]   q_hops,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [idx_w(MAX_NEXT_HOPS)-1:0]   hop_index,
    output logic [HASH_W-1:0]                 flow_hash,
    output logic                              select_error
);

    localparam int HOP_W  = hop_w(MAX_NEXT_HOPS);
    localparam int IDX_W  = idx_w(MAX_NEXT_HOPS);
    localparam int STAGES = HASH_STAGES + MOD_STAGES;

    // shift/subtract remainder over a few dividend bits
    function automatic logic [IDX_W-1:0] mod_step(input logic [IDX_W-1:0] r,
                                                  input logic [MOD_BITS_PER_STAGE-1:0] bits,
                                                  input logic [HOP_W-1:0] d);
        logic [IDX_W:0]   t;
        logic [IDX_W:0]   dd;
        logic [IDX_W-1:0] acc;
        acc = r;
        dd  = (IDX_W + 1)'(d);
        for (int b = MOD_BITS_PER_STAGE - 1; b >= 0; b--)
        begin
            t = {acc, bits[b]};
            if (t >= dd)
            begin
                t = t - dd;
            end
            acc = t[IDX_W-1:0];
        end
        return acc;
    endfunction

    logic              en;
    logic              valid_reg [STAGES];
    logic              err_reg   [STAGES];
    // the last remainder stage needs no divisor
    logic [HOP_W-1:0]  hops_reg  [STAGES-1];

    logic [HASH_W-1:0] ka1_reg, kb1_reg, kc1_reg;
    logic [HASH_W-1:0] ka2_reg, kb2_reg, kc2_reg;
    logic [HASH_W-1:0] h3_reg, kb3_reg, kc3_reg;
    logic [HASH_W-1:0] h4_reg, kc4_reg;
    logic [HASH_W-1:0] h5_reg;
    logic [HASH_W-1:0] h6_reg;
    logic [HASH_W-1:0] h7_reg;
    logic [HASH_W-1:0] h8_reg;
    logic [HASH_W-1:0] x6;
    logic [HASH_W-1:0] x7;

    logic [HASH_W-1:0] mhash_reg [MOD_STAGES];
    logic [IDX_W-1:0]  rem_reg   [MOD_STAGES];

    logic              out_valid_reg;
    logic [IDX_W-1:0]  hop_index_reg;
    logic [HASH_W-1:0] flow_hash_reg;
    logic              select_error_reg;

    // whole pipeline holds while a finished beat waits at the output
    assign en    = !(out_valid_reg && out_stall);
    assign q_pop = en && q_status.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= q_status.valid;
            for (int i = 1; i < STAGES; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
            out_valid_reg <= valid_reg[STAGES-1];
        end
    end

    assign x6 = (h5_reg ^ KEY_BYTES) ^ ((h5_reg ^ KEY_BYTES) >> 16);
    assign x7 = h6_reg ^ (h6_reg >> 13);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg[0]  <= q_err;
            hops_reg[0] <= q_hops;
            for (int i = 1; i < STAGES; i++)
            begin
                err_reg[i]  <= err_reg[i-1];
            end
            for (int i = 1; i < STAGES - 1; i++)
            begin
                hops_reg[i] <= hops_reg[i-1];
            end

            ka1_reg <= q_key.w0 * MM_C1;
            kb1_reg <= q_key.w1 * MM_C1;
            kc1_reg <= q_key.w2 * MM_C1;

            ka2_reg <= rotl15(ka1_reg) * MM_C2;
            kb2_reg <= rotl15(kb1_reg) * MM_C2;
            kc2_reg <= rotl15(kc1_reg) * MM_C2;

            h3_reg  <= mix_h(hash_seed, ka2_reg);
            kb3_reg <= kb2_reg;
            kc3_reg <= kc2_reg;

            h4_reg  <= mix_h(h3_reg, kb3_reg);
            kc4_reg <= kc3_reg;

            h5_reg  <= mix_h(h4_reg, kc4_reg);

            h6_reg  <= x6 * MM_F1;
            h7_reg  <= x7 * MM_F2;
            h8_reg  <= h7_reg ^ (h7_reg >> 16);
        end
    end

    genvar j;
    generate
        for (j = 0; j < MOD_STAGES; j++)
        begin : g_mod
            if (j == 0)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        mhash_reg[j] <= h8_reg;
                        rem_reg[j]   <= mod_step('0,
                            h8_reg[HASH_W-1 -: MOD_BITS_PER_STAGE],
                            hops_reg[HASH_STAGES-1]);
                    end
                end
            end
            else
            begin : g_rest
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        mhash_reg[j] <= mhash_reg[j-1];
                        rem_reg[j]   <= mod_step(rem_reg[j-1],
                            mhash_reg[j-1][HASH_W-1-MOD_BITS_PER_STAGE*j -: MOD_BITS_PER_STAGE],
                            hops_reg[HASH_STAGES+j-1]);
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hop_index_reg    <= err_reg[STAGES-1] ? '0 : rem_reg[MOD_STAGES-1];
            flow_hash_reg    <= mhash_reg[MOD_STAGES-1];
            select_error_reg <= err_reg[STAGES-1];
        end
    end

    assign out_valid    = out_valid_reg;
    assign hop_index    = hop_index_reg;
    assign flow_hash    = flow_hash_reg;
    assign select_error = select_error_reg;

endmodule

// File: tb/sv/ecmp_flow_hash_next_hop_select_checker.sv
`timescale 1ns / 100ps
// result checker for the ecmp next-hop selector: predicts each beat and compares
// depends on ecmp_pkg for widths, protocol numbers and hash constants

module ecmp_flow_hash_next_hop_select_checker
    import ecmp_pkg::*;
#(
    parameter int MAX_NEXT_HOPS = DEF_MAX_NEXT_HOPS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              hash_seed_we,
    input  logic [HASH_W-1:0]                 hash_seed_wdata,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [ADDR_W-1:0]                 src_addr,
    input  logic [ADDR_W-1:0]                 dst_addr,
    input  logic [PROTO_W-1:0]                protocol,
    input  logic [PORT_W-1:0]                 src_port,
    input  logic [PORT_W-1:0]                 dst_port,
    input  logic [hop_w(MAX_NEXT_HOPS)-1:0]   hop_count,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [idx_w(MAX_NEXT_HOPS)-1:0]   hop_index,
    input  logic [HASH_W-1:0]                 flow_hash,
    input  logic                              select_error,
    output int                                mismatch_count,
    output int                                picks_waiting,
    output int                                picks_checked,
    output int                                error_picks
);

    localparam int HW = hop_w(MAX_NEXT_HOPS);
    localparam int IW = idx_w(MAX_NEXT_HOPS);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [IW-1:0]     hop_index;
        logic [HASH_W-1:0] flow_hash;
        logic              select_error;
    } hop_pick_t;

    hop_pick_t         hop_pick_q[$];
    hop_pick_t         got_pick;
    hop_pick_t         want_pick;
    logic [HASH_W-1:0] seed_reg;
    int                mismatches;
    int                checked;
    int                flagged;

    function automatic logic [HASH_W-1:0] rol(input logic [HASH_W-1:0] x, input int r);
        return (x << r) | (x >> (HASH_W - r));
    endfunction

    // one body round of murmur3 for a 32-bit key word
    function automatic logic [HASH_W-1:0] fold_word(input logic [HASH_W-1:0] h,
                                                    input logic [HASH_W-1:0] k);
        logic [HASH_W-1:0] kk;
        logic [HASH_W-1:0] hh;
        kk = k * MM_C1;
        kk = rol(kk, 15);
        kk = kk * MM_C2;
        hh = rol(h ^ kk, 13);
        return hh * 32'd5 + MM_N;
    endfunction

    function automatic logic [HASH_W-1:0] murmur_flow(input logic [HASH_W-1:0] sa, da, w2,
                                                      input logic [HASH_W-1:0] seed);
        logic [HASH_W-1:0] h;
        h = fold_word(seed, sa);
        h = fold_word(h, da);
        h = fold_word(h, w2);
        h = h ^ KEY_BYTES;
        h = h ^ (h >> 16);
        h = h * MM_F1;
        h = h ^ (h >> 13);
        h = h * MM_F2;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic hop_pick_t predict_next_hop(input logic [ADDR_W-1:0] sa, da,
                                                   input logic [PROTO_W-1:0] proto,
                                                   input logic [PORT_W-1:0] sp, dp,
                                                   input logic [HW-1:0] hops,
                                                   input logic [HASH_W-1:0] seed);
        hop_pick_t p;
        logic      proto_ok;
        logic      hops_ok;
        p.flow_hash = murmur_flow(sa, da, {dp, sp}, seed);
        proto_ok = (proto == PROTO_TCP) || (proto == PROTO_UDP) ||
                   (proto == PROTO_ACK) || (proto == PROTO_NACK);
        hops_ok = (hops != '0) && (hops <= MAX_NEXT_HOPS);
        p.select_error = !(proto_ok && hops_ok);
        p.hop_index = '0;
        if (!p.select_error)
        begin
            p.hop_index = IW'(p.flow_hash % hops);
        end
        return p;
    endfunction

    task automatic note_mismatch(input string what, input hop_pick_t want, input hop_pick_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("%0t mismatch (%s): expected idx %0d hash %h err %0d,",
                     $realtime, what, want.hop_index, want.flow_hash, want.select_error);
            $display("    got idx %0d hash %h err %0d",
                     got.hop_index, got.flow_hash, got.select_error);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            hop_pick_q.delete();
            mismatches = 0;
            checked = 0;
            flagged = 0;
        end
        else
        begin
            // result side first so a same-edge input never pairs with it
            if (out_valid && !out_stall)
            begin
                got_pick.hop_index = hop_index;
                got_pick.flow_hash = flow_hash;
                got_pick.select_error = select_error;
                if (hop_pick_q.size() == 0)
                begin
                    note_mismatch("no beat pending", '0, got_pick);
                end
                else
                begin
                    want_pick = hop_pick_q.pop_front();
                    if (got_pick.hop_index !== want_pick.hop_index ||
                        got_pick.flow_hash !== want_pick.flow_hash ||
                        got_pick.select_error !== want_pick.select_error)
                    begin
                        note_mismatch("field differs", want_pick, got_pick);
                    end
                    checked++;
                    if (want_pick.select_error)
                    begin
                        flagged++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                hop_pick_q = {hop_pick_q, predict_next_hop(src_addr, dst_addr, protocol,
                                                           src_port, dst_port, hop_count,
                                                           seed_reg)};
            end
            if (hash_seed_we)
            begin
                seed_reg <= hash_seed_wdata;
            end
        end
        mismatch_count <= mismatches;
        picks_waiting <= hop_pick_q.size();
        picks_checked <= checked;
        error_picks <= flagged;
    end

endmodule

// File: tb/sv/ecmp_flow_hash_next_hop_select_test.sv
`timescale 1ns / 100ps
// top of the ecmp next-hop selector testbench: clock, reset, header and stall stimulus
// depends on ecmp_pkg, ecmp_flow_hash_next_hop_select and the result checker

module ecmp_flow_hash_next_hop_select_test
    import ecmp_pkg::*;
();

    localparam int MAX_HOPS     = DEF_MAX_NEXT_HOPS;
    localparam int HW           = hop_w(MAX_HOPS);
    localparam int IW           = idx_w(MAX_HOPS);
    // watchdog limit, leaving a wide margin over the slowest run
    localparam int CYCLE_LIMIT  = 200000;
    // receiver hold-off, long enough to fill the front register, queue and pipes
    localparam int LONG_HOLD    = 200;
    // extra wait at the end, after the last phase has drained
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_BEATS  = 260;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 hash_seed_we = 1'b0;
    logic [HASH_W-1:0]    hash_seed_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [ADDR_W-1:0]    src_addr = '0;
    logic [ADDR_W-1:0]    dst_addr = '0;
    logic [PROTO_W-1:0]   protocol = '0;
    logic [PORT_W-1:0]    src_port = '0;
    logic [PORT_W-1:0]    dst_port = '0;
    logic [HW-1:0]        hop_count = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [IW-1:0]        hop_index;
    logic [HASH_W-1:0]    flow_hash;
    logic                 select_error;

    int                   mismatch_count;
    int                   picks_waiting;
    int                   picks_checked;
    int                   error_picks;

    // sender and receiver idle odds, percent per cycle
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    // long hold-off requests, served by the receiver process
    int                   hold_asked = 0;
    int                   hold_served = 0;
    int                   hold_left = 0;
    int                   headers_sent = 0;
    int                   cycle_count = 0;
    logic [HASH_W-1:0]    seed_b;
    logic [HASH_W-1:0]    seed_c;

    ecmp_flow_hash_next_hop_select #(
        .MAX_NEXT_HOPS   (MAX_HOPS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .hash_seed_we    (hash_seed_we),
        .hash_seed_wdata (hash_seed_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .src_addr        (src_addr),
        .dst_addr        (dst_addr),
        .protocol        (protocol),
        .src_port        (src_port),
        .dst_port        (dst_port),
        .hop_count       (hop_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hop_index       (hop_index),
        .flow_hash       (flow_hash),
        .select_error    (select_error)
    );

    ecmp_flow_hash_next_hop_select_checker #(
        .MAX_NEXT_HOPS   (MAX_HOPS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .hash_seed_we    (hash_seed_we),
        .hash_seed_wdata (hash_seed_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .src_addr        (src_addr),
        .dst_addr        (dst_addr),
        .protocol        (protocol),
        .src_port        (src_port),
        .dst_port        (dst_port),
        .hop_count       (hop_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hop_index       (hop_index),
        .flow_hash       (flow_hash),
        .select_error    (select_error),
        .mismatch_count  (mismatch_count),
        .picks_waiting   (picks_waiting),
        .picks_checked   (picks_checked),
        .error_picks     (error_picks)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side back-pressure: a requested long hold-off wins over random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served <= hold_asked;
            hold_left <= LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped at cycle limit %0d, %0d beats still pending",
                     CYCLE_LIMIT, picks_waiting);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one header beat: optional idle cycles, then hold the payload until taken
    task automatic offer_header(input logic [ADDR_W-1:0] sa, da,
                                input logic [PROTO_W-1:0] proto,
                                input logic [PORT_W-1:0] sp, dp,
                                input logic [HW-1:0] hops);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        src_addr <= sa;
        dst_addr <= da;
        protocol <= proto;
        src_port <= sp;
        dst_port <= dp;
        hop_count <= hops;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        headers_sent++;
    endtask

    // mostly valid headers with random content, some bad protocols and hop counts
    task automatic offer_random_header();
        logic [ADDR_W-1:0]  sa;
        logic [ADDR_W-1:0]  da;
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  sp;
        logic [PORT_W-1:0]  dp;
        logic [HW-1:0]      hops;
        int                 roll;
        sa = $urandom;
        da = $urandom;
        sp = PORT_W'($urandom_range(16'hFFFF));
        dp = PORT_W'($urandom_range(16'hFFFF));
        // occasional corner addresses and ports
        if ($urandom_range(15) == 0)
        begin
            sa = $urandom_range(1) ? '1 : '0;
            dp = $urandom_range(1) ? '1 : '0;
        end
        roll = $urandom_range(99);
        if (roll < 85)
        begin
            case ($urandom_range(3))
                0: proto = PROTO_TCP;
                1: proto = PROTO_UDP;
                2: proto = PROTO_ACK;
                default: proto = PROTO_NACK;
            endcase
        end
        else
        begin
            proto = PROTO_W'($urandom_range(255));
        end
        roll = $urandom_range(99);
        if (roll < 6)
        begin
            hops = '0;
        end
        else if (roll < 14)
        begin
            hops = HW'($urandom_range((1 << HW) - 1, MAX_HOPS + 1));
        end
        else if (roll < 30)
        begin
            // powers of two up to the maximum
            hops = HW'(1 << $urandom_range(6));
        end
        else
        begin
            hops = HW'($urandom_range(MAX_HOPS, 1));
        end
        offer_header(sa, da, proto, sp, dp, hops);
    endtask

    task automatic load_seed(input logic [HASH_W-1:0] value);
        hash_seed_wdata <= value;
        hash_seed_we <= 1'b1;
        @(posedge clk);
        hash_seed_we <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid and wait until every predicted beat has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (picks_waiting != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input logic [HASH_W-1:0] seed, input int send_pct,
                             input int recv_pct, input bit long_hold);
        load_seed(seed);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        if (long_hold)
        begin
            hold_asked <= hold_asked + 1;
        end
        repeat (PHASE_BEATS)
        begin
            offer_random_header();
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed headers under the reset seed of zero
        offer_header('0, '0, PROTO_TCP, '0, '0, 7'd1);
        offer_header('1, '1, PROTO_UDP, '1, '1, 7'd64);
        offer_header(32'h0a00_0001, 32'hc0a8_0101, PROTO_ACK, 16'd4791, 16'd4791, 7'd63);
        offer_header(32'hdead_beef, 32'h1234_5678, PROTO_NACK, 16'h8000, 16'h0001, 7'd2);
        offer_header(32'h5555_5555, 32'haaaa_aaaa, PROTO_TCP, 16'h5555, 16'haaaa, 7'd3);
        offer_header(32'haaaa_aaaa, 32'h5555_5555, PROTO_UDP, 16'haaaa, 16'h5555, 7'd33);
        // only one port set, the other zero
        offer_header(32'h0102_0304, 32'h0506_0708, PROTO_TCP, 16'hffff, 16'h0000, 7'd17);
        offer_header(32'h0102_0304, 32'h0506_0708, PROTO_TCP, 16'h0000, 16'hffff, 7'd17);
        // unsupported protocols, hash still reported
        offer_header(32'h0a0a_0a0a, 32'h0b0b_0b0b, 8'd0, 16'd80, 16'd443, 7'd8);
        offer_header(32'h0a0a_0a0a, 32'h0b0b_0b0b, 8'd255, 16'd80, 16'd443, 7'd8);
        offer_header(32'h0a0a_0a0a, 32'h0b0b_0b0b, 8'd5, 16'd80, 16'd443, 7'd8);
        offer_header(32'h0a0a_0a0a, 32'h0b0b_0b0b, 8'd7, 16'd80, 16'd443, 7'd8);
        offer_header(32'h0a0a_0a0a, 32'h0b0b_0b0b, 8'd16, 16'd80, 16'd443, 7'd8);
        offer_header(32'h0a0a_0a0a, 32'h0b0b_0b0b, 8'd18, 16'd80, 16'd443, 7'd8);
        offer_header(32'h0a0a_0a0a, 32'h0b0b_0b0b, 8'd251, 16'd80, 16'd443, 7'd8);
        offer_header(32'h0a0a_0a0a, 32'h0b0b_0b0b, 8'd254, 16'd80, 16'd443, 7'd8);
        // zero hop count and hop counts above the maximum
        offer_header(32'hffff_0000, 32'h0000_ffff, PROTO_UDP, 16'd1, 16'd2, 7'd0);
        offer_header(32'hffff_0000, 32'h0000_ffff, PROTO_UDP, 16'd1, 16'd2, 7'd65);
        offer_header(32'hffff_0000, 32'h0000_ffff, PROTO_UDP, 16'd1, 16'd2, 7'd127);
        // bad protocol together with zero hops
        offer_header(32'h8000_0000, 32'h0000_0001, 8'd1, 16'd9, 16'd9, 7'd0);

        // sender pauses here until every result is back
        wait_drained();

        // random phases: seed all ones with a long receiver hold-off, then random seeds
        seed_b = $urandom;
        seed_c = $urandom;
        run_phase(32'hffff_ffff, 10, 64, 1'b1);
        run_phase(seed_b, 64, 10, 1'b0);
        run_phase(seed_c, 0, 0, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d header beats sent, %0d results checked, %0d with the error flag",
                 headers_sent, picks_checked, error_picks);
        $display("seeds 00000000 ffffffff %h %h, %0d mismatches",
                 seed_b, seed_c, mismatch_count);
        if (mismatch_count == 0 && picks_waiting == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/ecmp_pkg.sv
rtl/ecmp_front.sv
rtl/ecmp_queue.sv
rtl/ecmp_back.sv
rtl/ecmp_flow_hash_next_hop_select.sv
tb/sv/ecmp_flow_hash_next_hop_select_checker.sv
tb/sv/ecmp_flow_hash_next_hop_select_test.sv
